// ----- hdl/btf_pkg.sv -----
package btf_pkg;

  localparam int unsigned MONITORS_DEF = 64;
  localparam int unsigned GROUPS_DEF   = 16;

  localparam int unsigned MON_FIELD_W = 6;
  localparam int unsigned GRP_FIELD_W = 4;
  localparam int unsigned BYTES_W     = 64;
  localparam int unsigned TGT_W       = 32;
  localparam int unsigned BW_W        = 44;
  localparam int unsigned SUM_W       = 48;
  localparam int unsigned LVL_W       = 7;
  localparam int unsigned SZ_1M_SHIFT = 20;

  localparam logic [LVL_W-1:0] LEVEL_FULL = LVL_W'(100);

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 2'd2;

  localparam logic [LVL_W-1:0] MIN_LEVEL_RST = LVL_W'(10);
  localparam logic [LVL_W-1:0] STEP_SIZE_RST = LVL_W'(10);
  localparam logic [LVL_W-1:0] MAX_LEVEL_RST = LVL_W'(100);

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_ACCUM  = 2'd1,
    CMD_ADJUST = 2'd2,
    CMD_MARK   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                   cmd;
    logic [MON_FIELD_W-1:0] monitor;
    logic [GRP_FIELD_W-1:0] group;
    logic [BYTES_W-1:0]     byte_count;
    logic [TGT_W-1:0]       target_mbps;
  } in_req_t;

  typedef struct packed {
    logic [BW_W-1:0]  bw_mbps;
    logic [LVL_W-1:0] level;
    logic             changed;
  } res_t;

  typedef struct packed {
    logic [BYTES_W-1:0] last_bytes;
    logic [BW_W-1:0]    last_bw;
    logic [BW_W-1:0]    bw_change;
    logic               flag;
  } mon_entry_t;

endpackage

// ----- hdl/bandwidth_throttle_feedback.sv -----
// Memory-bandwidth throttle controller, one command per request.
// Request channel: a request is taken at a rising edge with start high and
// busy low. busy never rises, so a request may be issued in every cycle.
// Each request gives exactly one result on res_o, marked by res_valid_o for
// one cycle; it passes stage 1, stage 2 and the result register first. The
// receiver cannot hold results off; there is no stall path.
// Throughput: one request per cycle, set by the three-stage pipeline around
// the per-monitor and per-group memories (read on accept, compute the
// counter delta, then the absolute change, sums and level step, write back).
// Back-to-back requests to the same monitor or group see the pending write
// through bypass paths.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i (0 min level,
// 1 step size, 2 max level) and cfg_data_i; ready is always high. Write it
// only while no request is in flight.
// Reset: levels read as 100, monitor history and sums as zero, min level
// and step 10, max level 100. Valid bits cover the memories, so the block
// takes requests as soon as reset is released.
module bandwidth_throttle_feedback #(
  parameter int unsigned MONITORS = btf_pkg::MONITORS_DEF,
  parameter int unsigned GROUPS   = btf_pkg::GROUPS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  btf_pkg::in_req_t                     req_i,
  output logic                                 res_valid_o,
  output btf_pkg::res_t                        res_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [btf_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [btf_pkg::LVL_W-1:0]            cfg_data_i
);

  import btf_pkg::*;

  localparam int unsigned MonAw   = (MONITORS > 1) ? $clog2(MONITORS) : 1;
  localparam int unsigned GrpAw   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int unsigned EntryW  = $bits(mon_entry_t);

  logic accept;

  logic [LVL_W-1:0] min_level_q, step_size_q, max_level_q;

  logic             s1_vld_q;
  in_req_t          s1_req_q;
  logic [MonAw-1:0] s1_midx;
  logic [GrpAw-1:0] s1_gidx;
  logic             s1_mon_ok, s1_grp_ok;
  mon_entry_t       s1_ment;
  logic [LVL_W-1:0] s1_lvl;
  logic [BYTES_W-1:0] s1_diff;

  logic               s2_vld_q;
  cmd_e               s2_cmd_q;
  logic               s2_mon_ok_q, s2_grp_ok_q;
  logic [MonAw-1:0]   s2_midx_q;
  logic [GrpAw-1:0]   s2_gidx_q;
  logic [BYTES_W-1:0] s2_bytes_q;
  logic [TGT_W-1:0]   s2_target_q;
  logic [BW_W-1:0]    s2_bw_q;
  mon_entry_t         s2_ment_q;
  logic [LVL_W-1:0]   s2_lvl_q;

  logic [EntryW-1:0] mon_rdata;
  logic [LVL_W-1:0]  lvl_rdata;
  logic [MONITORS-1:0] mon_vld_q;
  logic [GROUPS-1:0]   grp_vld_q;

  logic             lw_mon_vld_q;
  logic [MonAw-1:0] lw_midx_q;
  mon_entry_t       lw_ment_q;
  logic             lw_grp_vld_q;
  logic [GrpAw-1:0] lw_gidx_q;
  logic [LVL_W-1:0] lw_lvl_q;

  logic            mon_wr;
  mon_entry_t      mon_wdata;
  logic [BW_W:0]   d_up, d_dn;
  logic [BW_W-1:0] bw_delta;

  logic [SUM_W-1:0] sum_bw_q, sum_bw_d, sum_chg_q, sum_chg_d;
  logic [SUM_W:0]   acc_bw, acc_chg, sum_tot;
  logic             tgt_lt_bw, tgt_gt_tot;

  logic             step_dn, step_up, lvl_wr;
  logic [LVL_W-1:0] lvl_sub, lvl_new;
  logic [LVL_W:0]   lvl_add;

  logic res_valid_q;
  res_t res_q, res_d;

  assign busy        = 1'b0;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_level_q <= MIN_LEVEL_RST;
      step_size_q <= STEP_SIZE_RST;
      max_level_q <= MAX_LEVEL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MIN_LEVEL: min_level_q <= cfg_data_i;
        CFG_STEP_SIZE: step_size_q <= cfg_data_i;
        CFG_MAX_LEVEL: max_level_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  btf_ram #(.Width(EntryW), .Depth(MONITORS)) u_mon_ram (
    .clk_i   (clk_i),
    .we_i    (mon_wr),
    .waddr_i (s2_midx_q),
    .wdata_i (mon_wdata),
    .raddr_i (MonAw'(req_i.monitor)),
    .rdata_o (mon_rdata)
  );

  btf_ram #(.Width(LVL_W), .Depth(GROUPS)) u_lvl_ram (
    .clk_i   (clk_i),
    .we_i    (lvl_wr),
    .waddr_i (s2_gidx_q),
    .wdata_i (lvl_new),
    .raddr_i (GrpAw'(req_i.group)),
    .rdata_o (lvl_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q     <= 1'b0;
      s2_vld_q     <= 1'b0;
      res_valid_q  <= 1'b0;
      lw_mon_vld_q <= 1'b0;
      lw_grp_vld_q <= 1'b0;
      mon_vld_q    <= '0;
      grp_vld_q    <= '0;
      sum_bw_q     <= '0;
      sum_chg_q    <= '0;
    end else begin
      s1_vld_q     <= accept;
      s2_vld_q     <= s1_vld_q;
      res_valid_q  <= s2_vld_q;
      lw_mon_vld_q <= mon_wr;
      lw_grp_vld_q <= lvl_wr;
      if (mon_wr) begin
        mon_vld_q[s2_midx_q] <= 1'b1;
      end
      if (lvl_wr) begin
        grp_vld_q[s2_gidx_q] <= 1'b1;
      end
      sum_bw_q  <= sum_bw_d;
      sum_chg_q <= sum_chg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_req_q    <= req_i;
    s2_cmd_q    <= s1_req_q.cmd;
    s2_mon_ok_q <= s1_mon_ok;
    s2_grp_ok_q <= s1_grp_ok;
    s2_midx_q   <= s1_midx;
    s2_gidx_q   <= s1_gidx;
    s2_bytes_q  <= s1_req_q.byte_count;
    s2_target_q <= s1_req_q.target_mbps;
    s2_bw_q     <= s1_diff[SZ_1M_SHIFT +: BW_W];
    s2_ment_q   <= s1_ment;
    s2_lvl_q    <= s1_lvl;
    lw_midx_q   <= s2_midx_q;
    lw_ment_q   <= mon_wdata;
    lw_gidx_q   <= s2_gidx_q;
    lw_lvl_q    <= lvl_new;
    res_q       <= res_d;
  end

  assign s1_midx   = MonAw'(s1_req_q.monitor);
  assign s1_gidx   = GrpAw'(s1_req_q.group);
  assign s1_mon_ok = 32'(s1_req_q.monitor) < 32'(MONITORS);
  assign s1_grp_ok = 32'(s1_req_q.group) < 32'(GROUPS);

  always_comb begin
    priority if (mon_wr && s2_midx_q == s1_midx) begin
      s1_ment = mon_wdata;
    end else if (lw_mon_vld_q && lw_midx_q == s1_midx) begin
      s1_ment = lw_ment_q;
    end else if (mon_vld_q[s1_midx]) begin
      s1_ment = mon_entry_t'(mon_rdata);
    end else begin
      s1_ment = '0;
    end
  end

  always_comb begin
    priority if (lvl_wr && s2_gidx_q == s1_gidx) begin
      s1_lvl = lvl_new;
    end else if (lw_grp_vld_q && lw_gidx_q == s1_gidx) begin
      s1_lvl = lw_lvl_q;
    end else if (grp_vld_q[s1_gidx]) begin
      s1_lvl = lvl_rdata;
    end else begin
      s1_lvl = LEVEL_FULL;
    end
  end

  assign s1_diff = s1_req_q.byte_count - s1_ment.last_bytes;

  assign mon_wr = s2_vld_q && s2_mon_ok_q
               && (s2_cmd_q == CMD_SAMPLE || s2_cmd_q == CMD_MARK);

  assign d_up     = {1'b0, s2_bw_q} - {1'b0, s2_ment_q.last_bw};
  assign d_dn     = {1'b0, s2_ment_q.last_bw} - {1'b0, s2_bw_q};
  assign bw_delta = d_up[BW_W] ? d_dn[BW_W-1:0] : d_up[BW_W-1:0];

  always_comb begin
    mon_wdata = s2_ment_q;
    if (s2_cmd_q == CMD_SAMPLE) begin
      mon_wdata.last_bytes = s2_bytes_q;
      mon_wdata.last_bw    = s2_bw_q;
      if (s2_ment_q.flag) begin
        mon_wdata.bw_change = bw_delta;
      end
      mon_wdata.flag = 1'b0;
    end else begin
      mon_wdata.flag = 1'b1;
    end
  end

  assign acc_bw  = {1'b0, sum_bw_q} + (SUM_W + 1)'(s2_ment_q.last_bw);
  assign acc_chg = {1'b0, sum_chg_q} + (SUM_W + 1)'(s2_ment_q.bw_change);
  assign sum_tot = {1'b0, sum_bw_q} + {1'b0, sum_chg_q};

  assign tgt_lt_bw  = SUM_W'(s2_target_q) < sum_bw_q;
  assign tgt_gt_tot = (SUM_W + 1)'(s2_target_q) > sum_tot;

  assign step_dn = (s2_lvl_q > min_level_q) && tgt_lt_bw;
  assign step_up = !step_dn && (s2_lvl_q < max_level_q) && tgt_gt_tot;
  assign lvl_sub = (s2_lvl_q >= step_size_q) ? s2_lvl_q - step_size_q : '0;
  assign lvl_add = {1'b0, s2_lvl_q} + {1'b0, step_size_q};

  always_comb begin
    if (step_dn) begin
      lvl_new = lvl_sub;
    end else if (step_up) begin
      lvl_new = lvl_add[LVL_W] ? '1 : lvl_add[LVL_W-1:0];
    end else begin
      lvl_new = s2_lvl_q;
    end
  end

  assign lvl_wr = s2_vld_q && s2_grp_ok_q && s2_cmd_q == CMD_ADJUST;

  always_comb begin
    sum_bw_d  = sum_bw_q;
    sum_chg_d = sum_chg_q;
    res_d     = '0;
    if (s2_vld_q) begin
      unique case (s2_cmd_q)
        CMD_SAMPLE: begin
          if (s2_mon_ok_q) begin
            res_d.bw_mbps = s2_bw_q;
          end
        end
        CMD_ACCUM: begin
          if (s2_mon_ok_q) begin
            sum_bw_d  = acc_bw[SUM_W] ? '1 : acc_bw[SUM_W-1:0];
            sum_chg_d = acc_chg[SUM_W] ? '1 : acc_chg[SUM_W-1:0];
          end
        end
        CMD_ADJUST: begin
          if (s2_grp_ok_q) begin
            sum_bw_d      = '0;
            sum_chg_d     = '0;
            res_d.level   = lvl_new;
            res_d.changed = step_dn || step_up;
          end
        end
        CMD_MARK: ;
        default: ;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- hdl/btf_ram.sv -----
module btf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
